// File: design/asdt_pkg.sv
package asdt_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned OPCODE_W     = 2;
    localparam int unsigned READ_IDX_W   = 4;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned FOUND_W      = 4;
    localparam int unsigned COUNT_OUT_W  = 5;
    localparam int unsigned DEF_TABLE_DEPTH = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ   = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_APPEND = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

endpackage

// File: design/asdt_if.sv
interface asdt_req_if;
    import asdt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic        [OPCODE_W-1:0]   opcode;
    logic signed [DATA_W-1:0]     key_value;
    logic        [READ_IDX_W-1:0] read_index;

    modport source (output valid, output opcode, output key_value, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input key_value, input read_index,
                    output ready);
endinterface

interface asdt_rsp_if;
    import asdt_pkg::*;

    logic                          valid;
    logic                          ready;
    logic        [STATUS_W-1:0]    status;
    logic        [FOUND_W-1:0]     found_index;
    logic signed [DATA_W-1:0]      read_value;
    logic        [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output status, output found_index, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found_index, input read_value,
                    input entry_count, output ready);
endinterface

// File: design/array_search_delete_table.sv
// Packed search-and-delete table.
//
// Requests arrive on i_req (valid/ready, with opcode, key_value and read_index);
// one response per request leaves on o_rsp (valid/ready, with status,
// found_index, read_value and entry_count). A request is taken only while the
// sequencer is idle; the block then works on it alone until its response is registered.
//
// A search compares one entry per cycle and stops at the first match; a delete
// scans the same way, then moves one entry down per cycle through the single
// table RAM port pair.
// Reset clears the entry count and all control state; the table contents are
// left as they are, and are never visible because only positions below the
// count can be read. A finished response sits in the output register until the
// receiver takes it; while it waits the block still accepts and works on the
// next request, and only stalls once that second response is ready too.
module array_search_delete_table #(
    parameter int unsigned TABLE_DEPTH = asdt_pkg::DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asdt_req_if.sink    i_req,
    asdt_rsp_if.source  o_rsp
);
    import asdt_pkg::*;

    // Position width, count width, and widened forms for comparison and output.
    localparam int unsigned IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned FW  = (IW > FOUND_W) ? IW : FOUND_W;
    localparam int unsigned NW  = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
    localparam int unsigned XW  = (CW > READ_IDX_W) ? CW : READ_IDX_W;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_ptr, n_ptr;
    logic                      r_cmp_valid, n_cmp_valid;
    logic [IW-1:0]             r_cmp_ptr, n_cmp_ptr;
    t_opcode                   r_op, n_op;
    logic signed [DATA_W-1:0]  r_key, n_key;
    logic [READ_IDX_W-1:0]     r_rd_idx, n_rd_idx;

    t_status                   r_res_status, n_res_status;
    logic [FOUND_W-1:0]        r_res_found, n_res_found;
    logic signed [DATA_W-1:0]  r_res_value, n_res_value;

    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status, n_out_status;
    logic [FOUND_W-1:0]        r_out_found, n_out_found;
    logic signed [DATA_W-1:0]  r_out_value, n_out_value;
    logic [COUNT_OUT_W-1:0]    r_out_count, n_out_count;

    logic                      we;
    logic [IW-1:0]             wr_addr;
    logic signed [DATA_W-1:0]  wr_data;
    logic [IW-1:0]             rd_addr;
    logic signed [DATA_W-1:0]  rd_data;

    logic                      issue;
    logic                      match;
    logic                      full;
    logic [FW-1:0]             in_idx_wide;
    logic [FW-1:0]             cmp_ptr_wide;
    logic [NW-1:0]             count_wide;
    logic [CW-1:0]             ptr_minus1;

    asdt_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The one shared comparator: the entry read last cycle against the key.
    assign match        = (rd_data == r_key);
    // Another position below the count remains to be fetched.
    assign issue        = (r_ptr < r_count);
    assign full         = (r_count == CW'(TABLE_DEPTH));
    assign in_idx_wide  = FW'(i_req.read_index);
    assign cmp_ptr_wide = FW'(r_cmp_ptr);
    assign count_wide   = NW'(r_count);
    assign ptr_minus1   = r_ptr - CW'(1);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_cmp_valid  = 1'b0;
        n_cmp_ptr    = r_cmp_ptr;
        n_op         = r_op;
        n_key        = r_key;
        n_rd_idx     = r_rd_idx;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        we           = 1'b0;
        wr_addr      = r_cmp_ptr;
        wr_data      = rd_data;
        rd_addr      = r_ptr[IW-1:0];
        i_req.ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                // Fetch the read position straight away so a read needs no extra step.
                rd_addr     = in_idx_wide[IW-1:0];
                if (i_req.valid) begin
                    n_op         = t_opcode'(i_req.opcode);
                    n_key        = i_req.key_value;
                    n_rd_idx     = i_req.read_index;
                    n_ptr        = '0;
                    n_res_status = ST_OK;
                    n_res_found  = '0;
                    n_res_value  = '0;
                    case (t_opcode'(i_req.opcode))
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        OP_SEARCH, OP_DELETE: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            // Append writes the new entry just past the last one in use.
                            if (!full) begin
                                we      = 1'b1;
                                wr_addr = r_count[IW-1:0];
                                wr_data = i_req.key_value;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_res_status = ST_FULL;
                            end
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (XW'(r_rd_idx) < XW'(r_count)) begin
                    n_res_value = rd_data;
                end else begin
                    n_res_status = ST_RANGE;
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                // Fetch one position per cycle while comparing the previous one.
                n_cmp_valid = issue;
                n_cmp_ptr   = r_ptr[IW-1:0];
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_cmp_valid && match) begin
                    n_res_found = cmp_ptr_wide[FOUND_W-1:0];
                    if (r_op == OP_DELETE) begin
                        n_ptr       = CW'(r_cmp_ptr) + CW'(1);
                        n_cmp_valid = 1'b0;
                        n_state     = S_SHIFT;
                    end else begin
                        n_state = S_RESP;
                    end
                end else if (!issue && !r_cmp_valid) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_RESP;
                end
            end
            S_SHIFT: begin
                // Read the entry above, then write it one place down next cycle.
                n_cmp_valid = issue;
                n_cmp_ptr   = ptr_minus1[IW-1:0];
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                end
                if (r_cmp_valid) begin
                    we = 1'b1;
                end
                if (!issue && !r_cmp_valid) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_value  = r_res_value;
                    n_out_count  = count_wide[COUNT_OUT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_cmp_ptr    <= n_cmp_ptr;
        r_op         <= n_op;
        r_key        <= n_key;
        r_rd_idx     <= n_rd_idx;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_index = r_out_found;
    assign o_rsp.read_value  = r_out_value;
    assign o_rsp.entry_count = r_out_count;

    // The count never passes the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Read and search requests leave the count untouched.
    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready &&
         (i_req.opcode == OP_READ || i_req.opcode == OP_SEARCH))
        |=> (r_count == $past(r_count)))
        else $error("count changed by a read or search");

    // Compaction only writes positions still in use.
    a_shift_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && we) |-> (CW'(wr_addr) < r_count))
        else $error("compaction write beyond count");

    // A new request is only taken while no entry move or scan is in flight.
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |-> !r_cmp_valid)
        else $error("request accepted during a scan");

endmodule

// File: design/asdt_ram.sv
module asdt_ram #(
    parameter int unsigned DEPTH  = asdt_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned ADDR_W = 4
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [ADDR_W-1:0]                   i_wr_addr,
    input  logic signed [asdt_pkg::DATA_W-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0]                   i_rd_addr,
    output logic signed [asdt_pkg::DATA_W-1:0]  o_rd_data
);
    import asdt_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;

    // Simple dual-port store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: test/asdt_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the table, keeps its own copy of the entries and
// predicts one response per accepted request.
module asdt_table_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    asdt_req_if   i_req_mon,
    asdt_rsp_if   i_rsp_mon,
    output int    o_fail_count,
    output int    o_pending
);
    import asdt_pkg::*;

    localparam int NO_MATCH   = -1;
    localparam int MAX_REPORT = 10;

    typedef struct {
        t_status                  status;
        logic [FOUND_W-1:0]       found_index;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } t_response;

    logic signed [DATA_W-1:0] shadow_entries [DEF_TABLE_DEPTH];
    int unsigned              shadow_count;
    t_response                pending_responses [$];
    int                       fail_count;

    // Applies one request to the shadow table and returns its response.
    function automatic t_response next_response(t_opcode op,
                                                logic signed [DATA_W-1:0] key,
                                                logic [READ_IDX_W-1:0] idx);
        t_response rsp;
        int        hit_pos;
        rsp.status      = ST_OK;
        rsp.found_index = '0;
        rsp.read_value  = '0;
        hit_pos         = NO_MATCH;
        case (op)
            OP_READ: begin
                if (idx < shadow_count) rsp.read_value = shadow_entries[idx];
                else rsp.status = ST_RANGE;
            end
            OP_SEARCH, OP_DELETE: begin
                for (int i = 0; i < shadow_count; i++)
                    if (hit_pos == NO_MATCH && shadow_entries[i] == key) hit_pos = i;
                if (hit_pos == NO_MATCH) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    rsp.found_index = hit_pos[FOUND_W-1:0];
                    if (op == OP_DELETE) begin
                        for (int i = hit_pos; i + 1 < shadow_count; i++)
                            shadow_entries[i] = shadow_entries[i+1];
                        shadow_count--;
                    end
                end
            end
            default: begin
                if (shadow_count < DEF_TABLE_DEPTH) begin
                    shadow_entries[shadow_count] = key;
                    shadow_count++;
                end else begin
                    rsp.status = ST_FULL;
                end
            end
        endcase
        rsp.entry_count = shadow_count[COUNT_OUT_W-1:0];
        return rsp;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORT) $display("%0t: %s", $realtime, what);
    endtask

    initial begin
        fail_count   = 0;
        shadow_count = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_response want;
        if (!i_rst_n) begin
            shadow_count = 0;
            pending_responses.delete();
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (pending_responses.size() == 0) begin
                    note_failure("response with no request outstanding");
                end else begin
                    want = pending_responses.pop_front();
                    if (want.status != i_rsp_mon.status
                        || want.found_index != i_rsp_mon.found_index
                        || want.read_value != i_rsp_mon.read_value
                        || want.entry_count != i_rsp_mon.entry_count)
                        note_failure($sformatf({"mismatch: expected status %0d index %0d ",
                            "value %0d count %0d, got status %0d index %0d value %0d ",
                            "count %0d"}, want.status, want.found_index, want.read_value,
                            want.entry_count, i_rsp_mon.status, i_rsp_mon.found_index,
                            i_rsp_mon.read_value, i_rsp_mon.entry_count));
                end
            end
            if (i_req_mon.valid && i_req_mon.ready)
                pending_responses.push_back(next_response(t_opcode'(i_req_mon.opcode),
                                                          i_req_mon.key_value,
                                                          i_req_mon.read_index));
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_responses.size();
    end

endmodule

// File: test/tb_array_search_delete_table.sv
`timescale 1ns / 1ps

// Top level of the table testbench. It makes the requests, drives the
// receiver's ready and gives the verdict; the checker beside the block does
// all of the prediction and comparison.
module tb_array_search_delete_table;
    import asdt_pkg::*;

    localparam int PHASE_REQUESTS = 432;
    localparam int BURST_LEN      = 40;
    localparam int SETTLE_CYCLES  = 40;
    localparam int POOL_SIZE      = 8;

    localparam logic signed [DATA_W-1:0] KEY_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] KEY_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] KEY_ZERO = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] KEY_ONES = 32'shFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    asdt_req_if req_if ();
    asdt_rsp_if rsp_if ();

    int fail_count;
    int pending;

    // Idle and stall chances, in percent of cycles, set per phase.
    int sender_idle_pct;
    int receiver_stall_pct;

    logic signed [DATA_W-1:0] key_pool [POOL_SIZE];

    array_search_delete_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    asdt_table_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The receiver decides afresh at every falling edge whether it will take
    // a response at the next rising edge.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Offers one request, possibly after some idle cycles, and returns at the
    // falling edge after it has been accepted. Valid is left high so that a
    // following request goes out back to back; only an idle cycle lowers it.
    task automatic send_request(t_opcode op, logic signed [DATA_W-1:0] key,
                                logic [READ_IDX_W-1:0] idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.opcode     = op;
        req_if.key_value  = key;
        req_if.read_index = idx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every outstanding response has arrived.
    task automatic drain_responses();
        req_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Most keys come from a small pool so that searches and deletes find
    // their targets; the rest are corner values or fully random.
    function automatic logic signed [DATA_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return key_pool[$urandom_range(POOL_SIZE-1)];
        if (roll < 70) begin
            case ($urandom_range(3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return KEY_ZERO;
                default: return KEY_ONES;
            endcase
        end
        return $urandom;
    endfunction

    // An append bias picked per burst lets the table drift between empty and
    // full, so that every fill level and the full case are visited.
    function automatic t_opcode pick_opcode(int append_pct);
        if ($urandom_range(99) < append_pct) return OP_APPEND;
        case ($urandom_range(2))
            0:       return OP_READ;
            1:       return OP_SEARCH;
            default: return OP_DELETE;
        endcase
    endfunction

    initial begin
        int append_pct;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_READ;
        req_if.key_value   = '0;
        req_if.read_index  = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        append_pct         = 50;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: the empty table answers a read, a search and a delete with
        // their error statuses before anything has been written.
        send_request(OP_READ,   KEY_ZERO, 4'd0);
        send_request(OP_SEARCH, KEY_ZERO, 4'd0);
        send_request(OP_DELETE, KEY_ZERO, 4'd0);

        // Extreme keys, and a duplicate so that the lowest match must win.
        send_request(OP_APPEND, KEY_MIN,  4'd0);
        send_request(OP_APPEND, KEY_MAX,  4'd0);
        send_request(OP_APPEND, KEY_ZERO, 4'd0);
        send_request(OP_APPEND, KEY_ONES, 4'd0);
        send_request(OP_APPEND, KEY_MAX,  4'd0);
        send_request(OP_SEARCH, KEY_MAX,  4'd0);
        send_request(OP_READ,   KEY_ZERO, 4'd4);
        send_request(OP_READ,   KEY_ZERO, 4'd5);

        // Fill the table to the top, then try one append too many, read the
        // very last position and delete the first entry so that every later
        // entry has to move down.
        repeat (DEF_TABLE_DEPTH - 5) send_request(OP_APPEND, $urandom, 4'd0);
        send_request(OP_APPEND, KEY_ONES, 4'd0);
        send_request(OP_READ,   KEY_ZERO, 4'd15);
        send_request(OP_DELETE, KEY_MIN,  4'd0);

        // Random part in four phases of idling: none, a sluggish sender, a
        // sluggish receiver, and both at once.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
                default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
            endcase
            foreach (key_pool[i]) key_pool[i] = $urandom;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % BURST_LEN == 0) begin
                    case ($urandom_range(3))
                        0:       append_pct = 10;
                        1:       append_pct = 30;
                        2:       append_pct = 50;
                        default: append_pct = 75;
                    endcase
                end
                // Once in the run the sender waits for the block to go quiet.
                if (phase == 1 && n == PHASE_REQUESTS / 2) drain_responses();
                send_request(pick_opcode(append_pct), pick_key(),
                             READ_IDX_W'($urandom_range(15)));
            end
        end

        req_if.valid = 1'b0;
        drain_responses();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Guard against a hung handshake; the slowest correct run is far shorter.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
